// ----- rtl/core/bds_pkg.sv -----
package bds_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_COMPONENTS = 4;
  localparam int LANES          = 4;
  localparam int LINE_DEPTH     = MAX_WIDTH / 2;

  localparam int COMP_W   = 8;
  localparam int PAIR_W   = COMP_W + 1;
  localparam int SUM_W    = COMP_W + 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int IDX_W    = $clog2(LINE_DEPTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = 13;
  localparam int HGT_W    = 13;
  localparam int CNT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WID_IN = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_COUNT = 2'd2;

  typedef logic [LANES-1:0][COMP_W-1:0] pixel_t;
  typedef logic [LANES-1:0][PAIR_W-1:0] pairs_t;
  typedef logic [LANES-1:0]             lane_en_t;

  typedef struct packed {
    logic             store;
    logic             emit;
    logic             eoi;
    logic [IDX_W-1:0] idx;
  } step_t;

endpackage

// ----- rtl/core/bds_ram.sv -----
module bds_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bds_ctrl.sv -----
module bds_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  bds_pkg::pixel_t                 pixel,
  output bds_pkg::step_t                  step,
  output bds_pkg::lane_en_t               lane_en,
  output bds_pkg::pairs_t                 pairs
);

  logic [bds_pkg::WID_W-1:0]      width;
  logic [bds_pkg::HGT_W-1:0]      height;
  logic [bds_pkg::CNT_W-1:0]      comp_count;
  logic [bds_pkg::COL_W-1:0]      column_count;
  logic [bds_pkg::ROW_W-1:0]      row_count;
  bds_pkg::pixel_t                left_pixel;

  logic [bds_pkg::CFG_WID_IN-1:0] w_in;
  logic [bds_pkg::CNT_W-1:0]      nc_in;
  logic [bds_pkg::WID_W-1:0]      used_w;
  logic [bds_pkg::HGT_W-1:0]      used_h;
  logic [bds_pkg::WID_W-1:0]      col_ext;
  logic [bds_pkg::WID_W-1:0]      col_inc;
  logic [bds_pkg::HGT_W-1:0]      row_ext;
  logic [bds_pkg::HGT_W-1:0]      row_inc;
  logic                           in_band;
  bds_pkg::pixel_t                lanes;

  assign w_in    = cfg_data[bds_pkg::CFG_WID_IN-1:0];
  assign nc_in   = cfg_data[bds_pkg::CNT_W-1:0];
  assign used_w  = {width[bds_pkg::WID_W-1:1], 1'b0};
  assign used_h  = {height[bds_pkg::HGT_W-1:1], 1'b0};
  assign col_ext = bds_pkg::WID_W'(column_count);
  assign col_inc = col_ext + 1'b1;
  assign row_ext = bds_pkg::HGT_W'(row_count);
  assign row_inc = row_ext + 1'b1;
  assign in_band = col_ext < used_w;

  always_comb begin
    for (int k = 0; k < bds_pkg::LANES; k++) begin
      lane_en[k] = k < int'(comp_count);
      lanes[k]   = lane_en[k] ? pixel[k] : '0;
      pairs[k]   = bds_pkg::PAIR_W'(left_pixel[k]) + bds_pkg::PAIR_W'(lanes[k]);
    end
  end

  always_comb begin
    step.store = in_band && column_count[0] && !row_count[0];
    step.emit  = in_band && column_count[0] && row_count[0];
    step.eoi   = (col_ext == used_w - 1'b1) && (row_ext == used_h - 1'b1);
    step.idx   = column_count[bds_pkg::COL_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= bds_pkg::WID_W'(bds_pkg::MAX_WIDTH);
      height       <= bds_pkg::HGT_W'(2048);
      comp_count   <= bds_pkg::CNT_W'(bds_pkg::MAX_COMPONENTS);
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (cfg_we) begin
      // any register write restarts the image
      unique case (cfg_index)
        bds_pkg::REG_IMAGE_WIDTH: begin
          if (w_in == '0) begin
            width <= bds_pkg::WID_W'(1);
          end else if (32'(w_in) > bds_pkg::MAX_WIDTH) begin
            width <= bds_pkg::WID_W'(bds_pkg::MAX_WIDTH);
          end else begin
            width <= bds_pkg::WID_W'(w_in);
          end
          column_count <= '0;
          row_count    <= '0;
        end
        bds_pkg::REG_IMAGE_HEIGHT: begin
          height       <= (cfg_data == '0) ? bds_pkg::HGT_W'(1) : cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        bds_pkg::REG_COMPONENT_COUNT: begin
          if (nc_in == '0) begin
            comp_count <= bds_pkg::CNT_W'(1);
          end else if (32'(nc_in) > bds_pkg::MAX_COMPONENTS) begin
            comp_count <= bds_pkg::CNT_W'(bds_pkg::MAX_COMPONENTS);
          end else begin
            comp_count <= nc_in;
          end
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (in_band && !column_count[0]) begin
        left_pixel <= lanes;
      end
      if (col_inc >= width) begin
        column_count <= '0;
        row_count    <= (row_inc >= height) ? '0 : row_inc[bds_pkg::ROW_W-1:0];
      end else begin
        column_count <= col_inc[bds_pkg::COL_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/core/bds_out.sv -----
module bds_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   eoi,
  input  bds_pkg::lane_en_t      lane_en,
  input  bds_pkg::pairs_t        pairs,
  input  bds_pkg::pairs_t        above,
  input  logic                   out_stall,
  output logic                   blocked,
  output logic                   out_valid,
  output bds_pkg::pixel_t        result,
  output logic                   end_of_image
);

  logic              s1_valid;
  logic              s1_eoi;
  bds_pkg::lane_en_t s1_lane_en;
  bds_pkg::pairs_t   s1_pairs;
  logic              s1_adv;
  bds_pkg::pixel_t   avg;
  logic [bds_pkg::SUM_W-1:0] sum [bds_pkg::LANES];

  assign s1_adv  = s1_valid && (!out_valid || !out_stall);
  assign blocked = s1_valid && out_valid && out_stall;

  // line-store data arrives in the cycle after the read, beside the stage 1 item
  always_comb begin
    for (int k = 0; k < bds_pkg::LANES; k++) begin
      sum[k] = bds_pkg::SUM_W'(above[k]) + bds_pkg::SUM_W'(s1_pairs[k]);
      avg[k] = s1_lane_en[k] ? sum[k][bds_pkg::SUM_W-1:2] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_eoi     <= eoi;
      s1_lane_en <= lane_en;
      s1_pairs   <= pairs;
    end
    if (s1_adv) begin
      result       <= avg;
      end_of_image <= s1_eoi;
    end
  end

endmodule

// ----- rtl/core/box_downsample_2x2.sv -----
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    in_c0..in_c3
// out      source     out_valid / out_stall  out_c0..out_c3, end_of_image
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock is taken while in_stall is low; each result passes through
// the stage 1 register, beside the registered line-store read, and the output register.
// Reset loads width 2048, height 2048, four components and restarts at row 0.
// in_stall rises only when both the middle stage and the output are held.
module box_downsample_2x2 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_c0,
  input  logic [7:0]                     in_c1,
  input  logic [7:0]                     in_c2,
  input  logic [7:0]                     in_c3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_c0,
  output logic [7:0]                     out_c1,
  output logic [7:0]                     out_c2,
  output logic [7:0]                     out_c3,
  output logic                           end_of_image,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              accept;
  logic              blocked;
  bds_pkg::pixel_t   pixel;
  bds_pkg::pixel_t   result;
  bds_pkg::step_t    step;
  bds_pkg::lane_en_t lane_en;
  bds_pkg::pairs_t   pairs;
  bds_pkg::pairs_t   above;

  assign cfg_ready = 1'b1;
  assign in_stall  = blocked;
  assign accept    = in_valid && !in_stall;
  assign pixel     = {in_c3, in_c2, in_c1, in_c0};
  assign out_c0    = result[0];
  assign out_c1    = result[1];
  assign out_c2    = result[2];
  assign out_c3    = result[3];

  bds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .step      (step),
    .lane_en   (lane_en),
    .pairs     (pairs)
  );

  bds_ram #(
    .WIDTH ($bits(bds_pkg::pairs_t)),
    .DEPTH (bds_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && step.store),
    .waddr (step.idx),
    .wdata (pairs),
    .re    (accept && step.emit),
    .raddr (step.idx),
    .rdata (above)
  );

  bds_out u_out (
    .clk          (clk),
    .rst          (rst),
    .take         (accept && step.emit),
    .eoi          (step.eoi),
    .lane_en      (lane_en),
    .pairs        (pairs),
    .above        (above),
    .out_stall    (out_stall),
    .blocked      (blocked),
    .out_valid    (out_valid),
    .result       (result),
    .end_of_image (end_of_image)
  );

endmodule

// ----- rtl/core/bds_chk.sv -----
module bds_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_c0,
  input logic [7:0]                     in_c1,
  input logic [7:0]                     in_c2,
  input logic [7:0]                     in_c3,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [7:0]                     out_c0,
  input logic [7:0]                     out_c1,
  input logic [7:0]                     out_c2,
  input logic [7:0]                     out_c3,
  input logic                           end_of_image,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bds_pkg::CFG_DATA_W-1:0] cfg_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_c0) && $stable(out_c1)
      && $stable(out_c2) && $stable(out_c3) && $stable(end_of_image))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only behind a held output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // a new result traces to an item accepted ahead of the stage 1 and output registers
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted item");

endmodule

bind box_downsample_2x2 bds_chk u_bds_chk (.*);
